// ===== sv/ptts_pkg.sv =====
// Package for the periodic task tick scheduler: beat structs, table entry
// layout, operation and event codes, and default sizing.
// No dependencies.
`default_nettype none

package ptts_pkg;

    // Default table depth and per-tick result cap
    localparam int MAX_TASKS_DEF = 8;
    localparam int RESULT_LIMIT  = 8;

    // Operation codes of the input beat
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_CREATE     = 2'd1;
    localparam logic [1:0] OP_ACTIVATE   = 2'd2;
    localparam logic [1:0] OP_DEACTIVATE = 2'd3;

    // Event codes of the result beat
    localparam logic [2:0] EV_RUN    = 3'd0;
    localparam logic [2:0] EV_FINISH = 3'd1;
    localparam logic [2:0] EV_START  = 3'd2;
    localparam logic [2:0] EV_STOP   = 3'd3;
    localparam logic [2:0] EV_CREATE = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  task_index;
        logic [15:0] interval_ticks;
        logic [7:0]  run_limit;
        logic        start_active;
    } sched_in_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [2:0] event_task;
        logic       last_event;
    } sched_out_t;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [15:0] interval;
        logic [15:0] elapsed;
        logic        ready;
        logic        active;
        logic [7:0]  runs_left;
    } entry_t;

    // Event produced by the entry update logic
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
    } entry_res_t;

    // Result beat handed from the table sequencer to the output register
    typedef struct packed {
        logic       valid;
        sched_out_t beat;
    } push_t;

endpackage

`default_nettype wire

// ===== sv/ptts_entry_alu.sv =====
// Entry update logic: computes the modified table entry and its event for
// tick, activate and deactivate. Depends on ptts_pkg.
`default_nettype none

module ptts_entry_alu
    import ptts_pkg::*;
(
    input  wire logic [1:0]  op,
    input  wire entry_t      entry_in,
    input  wire logic [15:0] interval_ticks,
    input  wire logic [7:0]  run_limit,
    input  wire logic        can_serve,
    output entry_t           entry_out,
    output entry_res_t       res
);

    always_comb begin
        entry_out = entry_in;
        res.valid = 1'b0;
        res.kind  = EV_RUN;
        case (op)
            OP_TICK: begin
                // count one tick on a waiting active entry, saturating
                if (entry_out.active && !entry_out.ready) begin
                    if (entry_out.elapsed != 16'hFFFF) begin
                        entry_out.elapsed = entry_out.elapsed + 16'd1;
                    end
                    if (entry_out.elapsed >= entry_out.interval) begin
                        entry_out.ready = 1'b1;
                    end
                end
                // service a ready active entry while result slots remain
                if (entry_out.active && entry_out.ready && can_serve) begin
                    entry_out.ready   = 1'b0;
                    entry_out.elapsed = 16'd0;
                    res.valid         = 1'b1;
                    if (entry_out.runs_left != 8'd0) begin
                        entry_out.runs_left = entry_out.runs_left - 8'd1;
                        if (entry_out.runs_left == 8'd0) begin
                            entry_out.active = 1'b0;
                            res.kind         = EV_FINISH;
                        end
                    end
                end
            end
            OP_ACTIVATE: begin
                entry_out.active    = 1'b1;
                entry_out.ready     = 1'b1;
                entry_out.runs_left = run_limit;
                if (interval_ticks != 16'd0) begin
                    entry_out.interval = interval_ticks;
                end
                res.valid = 1'b1;
                res.kind  = EV_START;
            end
            OP_DEACTIVATE: begin
                entry_out.active = 1'b0;
                entry_out.ready  = 1'b0;
                res.valid        = 1'b1;
                res.kind         = EV_STOP;
            end
            default: begin
                // create is written whole by the sequencer
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ptts_table.sv =====
// Task table: entry memory with a registered read port and the sequencer that
// reads, updates and writes back entries. Depends on ptts_pkg, ptts_entry_alu.
`default_nettype none

module ptts_table
    import ptts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sched_in_t s_data,
    input  wire logic      out_free,
    output push_t          push
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int UW = $clog2(MAX_TASKS + 1);
    localparam int TW = (UW > 3) ? UW : 3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]    state_reg, state_next;
    sched_in_t     item_reg, item_next;
    logic [UW-1:0] used_reg, used_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [3:0]    nres_reg, nres_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [2:0]    pend_kind_reg, pend_kind_next;
    logic [2:0]    pend_task_reg, pend_task_next;

    entry_t        mem [MAX_TASKS];
    entry_t        rdata_reg;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;

    entry_t        alu_entry;
    entry_res_t    alu_res;
    logic          can_serve;
    logic          stall;
    logic          full;
    logic          idx_bad;
    logic          sweep_last;
    logic [TW-1:0] idx_wide;
    logic [TW-1:0] ptr_wide;
    logic [TW-1:0] used_wide;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    ptts_entry_alu u_alu (
        .op             (item_reg.op),
        .entry_in       (rdata_reg),
        .interval_ticks (item_reg.interval_ticks),
        .run_limit      (item_reg.run_limit),
        .can_serve      (can_serve),
        .entry_out      (alu_entry),
        .res            (alu_res)
    );

    // Index checks and widened views of the counters
    always_comb begin
        idx_wide   = TW'(item_reg.task_index);
        ptr_wide   = TW'(ptr_reg);
        used_wide  = TW'(used_reg);
        full       = (used_reg == UW'(MAX_TASKS));
        idx_bad    = (idx_wide >= used_wide);
        sweep_last = ((UW'(ptr_reg) + UW'(1)) == used_reg);
        can_serve  = (nres_reg < 4'(RESULT_LIMIT));
        stall      = alu_res.valid && pend_valid_reg && !out_free;
    end

    // Sequencer: hold one pending event so the last one can be flagged
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_task_next  = pend_task_reg;
        s_ready         = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = alu_entry;
        push.valid      = 1'b0;
        push.beat.event_kind = pend_kind_reg;
        push.beat.event_task = pend_task_reg;
        push.beat.last_event = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                nres_next = 4'd0;
                case (item_reg.op)
                    OP_TICK: begin
                        ptr_next = '0;
                        if (used_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    OP_CREATE: begin
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                        if (full) begin
                            pend_kind_next = EV_ERROR;
                            pend_task_next = 3'd0;
                        end else begin
                            mem_we              = 1'b1;
                            mem_waddr           = used_reg[AW-1:0];
                            mem_wdata.interval  = item_reg.interval_ticks;
                            mem_wdata.elapsed   = 16'd0;
                            mem_wdata.ready     = 1'b1;
                            mem_wdata.active    = item_reg.start_active;
                            mem_wdata.runs_left = item_reg.run_limit;
                            used_next           = used_reg + UW'(1);
                            pend_kind_next      = EV_CREATE;
                            pend_task_next      = used_wide[2:0];
                        end
                    end
                    default: begin
                        if (idx_bad) begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = EV_ERROR;
                            pend_task_next  = item_reg.task_index;
                            state_next      = ST_FLUSH;
                        end else begin
                            ptr_next   = idx_wide[AW-1:0];
                            state_next = ST_READ;
                        end
                    end
                endcase
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (!stall) begin
                    mem_we = 1'b1;
                    if (alu_res.valid) begin
                        push.valid      = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = alu_res.kind;
                        pend_task_next  = ptr_wide[2:0];
                        nres_next       = nres_reg + 4'd1;
                    end
                    if (item_reg.op == OP_TICK && !sweep_last) begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push.valid           = 1'b1;
                    push.beat.last_event = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload and sweep registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        ptr_reg       <= ptr_next;
        nres_reg      <= nres_next;
        pend_kind_reg <= pend_kind_next;
        pend_task_reg <= pend_task_next;
    end

endmodule

`default_nettype wire

// ===== sv/periodic_task_tick_scheduler_unit.sv =====
// Top level of the periodic task tick scheduler: task table sequencer and
// result output register. Depends on ptts_pkg, ptts_table.
//
//   port group  | dir | handshake         | payload
//   s_*         | in  | s_valid / s_ready | s_data  (sched_in_t)
//   m_*         | out | m_valid / m_ready | m_data  (sched_out_t)
//
// A tick sweeps the used entries in index order: each entry is read from the
// entry memory in the read state and updated and written back in the modify
// state. A tick on an empty table returns straight to idle.
// aresetn is synchronous; it clears the entry count, the sequencer and the
// output register. Table entries are not cleared.
// A stalled m_ready holds the sweep once one event waits in the pending slot
// and another in the output register; s_ready is high only when idle.
`default_nettype none

module periodic_task_tick_scheduler_unit
    import ptts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire sched_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output sched_out_t      m_data
);

    logic       m_valid_reg;
    sched_out_t m_data_reg;
    logic       out_free;
    push_t      push;

    ptts_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .push     (push)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Output register: load a pushed beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_data_reg <= push.beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/ptts_checker.sv =====
// Port-level checker for the periodic task tick scheduler, bound to the top
// level. Depends on ptts_pkg.
`default_nettype none

module ptts_checker
    import ptts_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire sched_out_t m_data
);

    // Stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One item at a time: input closes right after a beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after accepting a beat");

    // More events of the same item still pending: input stays closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_event |-> !s_ready)
        else $error("input open while events of an item are pending");

    // Create, start, stop and error events are single-event items
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != EV_RUN && m_data.event_kind != EV_FINISH
        |-> m_data.last_event)
        else $error("single-event item not flagged as last");

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (.*);

`default_nettype wire

// ===== bench/tb_periodic_task_tick_scheduler_unit.sv =====
// Testbench for periodic_task_tick_scheduler_unit: drives command beats, predicts the
// event beats of the task table and compares every event beat in order.
// Depends on ptts_pkg and the scheduler RTL.
module tb_periodic_task_tick_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ptts_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned REPORT_MAX   = 10;

    // Task table predictor and the queue of event beats still due
    class task_event_board;
        logic [15:0] interval_tbl  [MAX_TASKS_DEF];
        logic [15:0] elapsed_tbl   [MAX_TASKS_DEF];
        bit          ready_tbl     [MAX_TASKS_DEF];
        bit          active_tbl    [MAX_TASKS_DEF];
        logic [7:0]  runs_left_tbl [MAX_TASKS_DEF];
        int unsigned tasks_created;
        sched_out_t  events_due[$];
        int unsigned mismatches;

        function new();
            tasks_created = 0;
            mismatches = 0;
        endfunction

        // Update the table for one accepted command and queue the events it causes
        function void note_command(sched_in_t cmd);
            sched_out_t caused[$];
            int unsigned i;
            case (cmd.op)
                OP_TICK: begin
                    // Advance waiting entries
                    for (i = 0; i < tasks_created; i++) begin
                        if (active_tbl[i] && !ready_tbl[i]) begin
                            if (elapsed_tbl[i] != 16'hFFFF)
                                elapsed_tbl[i] = elapsed_tbl[i] + 16'd1;
                            if (elapsed_tbl[i] >= interval_tbl[i])
                                ready_tbl[i] = 1'b1;
                        end
                    end
                    // Service ready entries in index order, capped per tick
                    for (i = 0; i < tasks_created; i++) begin
                        if (caused.size() >= RESULT_LIMIT)
                            break;
                        if (active_tbl[i] && ready_tbl[i]) begin
                            ready_tbl[i] = 1'b0;
                            elapsed_tbl[i] = 16'd0;
                            if (runs_left_tbl[i] != 8'd0) begin
                                runs_left_tbl[i] = runs_left_tbl[i] - 8'd1;
                                if (runs_left_tbl[i] == 8'd0) begin
                                    active_tbl[i] = 1'b0;
                                    caused.push_back('{EV_FINISH, 3'(i), 1'b0});
                                    continue;
                                end
                            end
                            caused.push_back('{EV_RUN, 3'(i), 1'b0});
                        end
                    end
                end
                OP_CREATE: begin
                    if (tasks_created >= MAX_TASKS_DEF) begin
                        caused.push_back('{EV_ERROR, 3'd0, 1'b0});
                    end else begin
                        i = tasks_created;
                        interval_tbl[i]  = cmd.interval_ticks;
                        elapsed_tbl[i]   = 16'd0;
                        ready_tbl[i]     = 1'b1;
                        active_tbl[i]    = cmd.start_active;
                        runs_left_tbl[i] = cmd.run_limit;
                        tasks_created    = i + 1;
                        caused.push_back('{EV_CREATE, 3'(i), 1'b0});
                    end
                end
                default: begin
                    i = cmd.task_index;
                    if (i >= tasks_created) begin
                        caused.push_back('{EV_ERROR, cmd.task_index, 1'b0});
                    end else if (cmd.op == OP_ACTIVATE) begin
                        active_tbl[i]    = 1'b1;
                        ready_tbl[i]     = 1'b1;
                        runs_left_tbl[i] = cmd.run_limit;
                        if (cmd.interval_ticks != 16'd0)
                            interval_tbl[i] = cmd.interval_ticks;
                        caused.push_back('{EV_START, cmd.task_index, 1'b0});
                    end else begin
                        active_tbl[i] = 1'b0;
                        ready_tbl[i]  = 1'b0;
                        caused.push_back('{EV_STOP, cmd.task_index, 1'b0});
                    end
                end
            endcase
            // Mark the closing event of this command
            if (caused.size() > 0)
                caused[caused.size() - 1].last_event = 1'b1;
            foreach (caused[k])
                events_due.push_back(caused[k]);
        endfunction

        // Compare one accepted event beat with the oldest one due
        function void check_event(sched_out_t got);
            sched_out_t want;
            if (events_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected event beat: kind %0d task %0d last %0d",
                             got.event_kind, got.event_task, got.last_event);
                return;
            end
            want = events_due.pop_front();
            if (got.event_kind !== want.event_kind || got.event_task !== want.event_task ||
                got.last_event !== want.last_event) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"event mismatch: expected kind %0d task %0d last %0d, ",
                              "got kind %0d task %0d last %0d"},
                             want.event_kind, want.event_task, want.last_event,
                             got.event_kind, got.event_task, got.last_event);
            end
        endfunction

        function int unsigned outstanding();
            return events_due.size();
        endfunction

        function bit clean();
            return mismatches == 0 && events_due.size() == 0;
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    sched_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    sched_out_t m_data;

    task_event_board board;
    int unsigned     sender_idle_pct = 0;
    int unsigned     receiver_idle_pct = 0;
    bit              hold_request = 1'b0;
    int unsigned     cycle_count = 0;

    periodic_task_tick_scheduler_unit #(
        .MAX_TASKS(MAX_TASKS_DEF)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_periodic_task_tick_scheduler_unit: FAIL");
            $finish;
        end
    end

    // Check every event beat taken by the sink
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_event(m_data);
    end

    // Event sink: random stalls, plus one long hold-off on request
    initial begin : event_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    function automatic sched_in_t make_command(logic [1:0] op, logic [2:0] idx,
                                               logic [15:0] interval, logic [7:0] limit,
                                               logic start);
        sched_in_t cmd;
        cmd.op = op;
        cmd.task_index = idx;
        cmd.interval_ticks = interval;
        cmd.run_limit = limit;
        cmd.start_active = start;
        return cmd;
    endfunction

    // Offer one command beat, with random idle cycles ahead of it
    task automatic send_command(input sched_in_t cmd);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        board.note_command(cmd);
    endtask

    // Random commands, mostly small intervals and run counts so entries keep firing
    task automatic run_random_phase(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct, input bit with_hold);
        sched_in_t   cmd;
        int unsigned pick;
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        if (with_hold)
            hold_request = 1'b1;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 50)
                cmd.op = OP_TICK;
            else if (pick < 75)
                cmd.op = OP_ACTIVATE;
            else if (pick < 90)
                cmd.op = OP_DEACTIVATE;
            else
                cmd.op = OP_CREATE;
            cmd.task_index = 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 70)
                cmd.interval_ticks = 16'($urandom_range(4));
            else if (pick < 85)
                cmd.interval_ticks = 16'($urandom_range(40, 5));
            else
                cmd.interval_ticks = 16'($urandom);
            cmd.run_limit = ($urandom_range(99) < 60) ? 8'($urandom_range(4)) : 8'($urandom);
            cmd.start_active = 1'($urandom);
            send_command(cmd);
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, bad indexes, creates, finishes, full table
        sender_idle_pct = 20;
        receiver_idle_pct = 64;
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_ACTIVATE,   3'd0, 16'd1,     8'd1,   1'b0));
        send_command(make_command(OP_DEACTIVATE, 3'd7, 16'd0,     8'd0,   1'b1));
        send_command(make_command(OP_CREATE,     3'd5, 16'd0,     8'd0,   1'b1));
        send_command(make_command(OP_CREATE,     3'd2, 16'hFFFF,  8'hFF,  1'b0));
        send_command(make_command(OP_CREATE,     3'd0, 16'd2,     8'd2,   1'b1));
        send_command(make_command(OP_ACTIVATE,   3'd3, 16'd4,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_ACTIVATE,   3'd1, 16'd0,     8'd1,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_ACTIVATE,   3'd2, 16'hFFFF,  8'd3,   1'b1));
        send_command(make_command(OP_DEACTIVATE, 3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_CREATE,     3'd7, 16'd1,     8'd0,   1'b1));
        send_command(make_command(OP_CREATE,     3'd0, 16'd0,     8'd0,   1'b1));
        send_command(make_command(OP_CREATE,     3'd0, 16'h8000,  8'd2,   1'b1));
        send_command(make_command(OP_CREATE,     3'd0, 16'd3,     8'd0,   1'b1));
        send_command(make_command(OP_CREATE,     3'd0, 16'd0,     8'd1,   1'b1));
        send_command(make_command(OP_CREATE,     3'd4, 16'd5,     8'd1,   1'b1));
        send_command(make_command(OP_ACTIVATE,   3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_ACTIVATE,   3'd1, 16'd1,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));
        send_command(make_command(OP_TICK,       3'd0, 16'd0,     8'd0,   1'b0));

        // Random: swap idling sides, then run flat out with one long sink hold-off
        run_random_phase(52, 20, 64, 1'b0);
        run_random_phase(52, 64, 20, 1'b0);
        run_random_phase(52, 0, 0, 1'b1);
        s_valid <= 1'b0;

        // Drain and let any stray beat show up
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.clean())
            $display("tb_periodic_task_tick_scheduler_unit: PASS");
        else
            $display("tb_periodic_task_tick_scheduler_unit: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ptts_pkg.sv
sv/ptts_entry_alu.sv
sv/ptts_table.sv
sv/periodic_task_tick_scheduler_unit.sv
sv/ptts_checker.sv
bench/tb_periodic_task_tick_scheduler_unit.sv
